// File: sv/olir_pkg.sv
// Shared types and constants of the ordered list with insert and remove.
package olir_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_HEAD  = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_REM_HEAD  = 3'd3,
    MODE_REM_MATCH = 3'd4,
    MODE_REM_TAIL  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_NOTFOUND = 2'd2,
    STATUS_FULL     = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Per-cell update command for one cycle.
  typedef struct packed {
    logic load;        // take the new value
    logic from_left;   // take the value of the neighbor nearer the head
    logic from_right;  // take the value of the neighbor nearer the tail
  } cell_ctrl_t;

endpackage

// File: sv/ordered_list_insert_remove.sv
// Top level of the bounded ordered list with insert and remove operations.
//
// Input beats arrive on the s_axis channel. tuser carries the operation mode,
// tdata carries the value and the insert position. Every input beat yields
// exactly one output beat on m_axis carrying the removed value, a status code
// and the list length after the operation.
//
// While a beat is offered, every cell compares its entry with the offered
// value; the accepting edge latches the operands together with the hit
// vector. Once the output register is free, the hit vector and the index
// compares drive a one-cycle shift of the cell row, and the result is written
// into the output register. A new beat is taken only after the shift step of
// the previous one, so beats do not overlap; the input rate is set by the
// compare-then-shift sequence of the cell row.
//
// The output register decouples the two sides: the next beat is accepted while
// a result still waits. If the receiver stalls, the shift step waits until the
// output register is free, and s_axis_tready stays low meanwhile.
//
// Reset empties the list at once by clearing the count; the cell contents are
// not cleared and are only read below the count.
module ordered_list_insert_remove
  import olir_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value [31:0], position [36:32], zero pad
  input  logic [2:0]  s_axis_tuser,   // mode [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // taken entry [31:0], status [33:32],
                                      // length [38:34], zero pad
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // Control state.
  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic             m_valid_q, m_valid_d;

  // Operands of the item at work.
  mode_e              mode_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   pos_q;
  logic [DEPTH-1:0]   hit_q, hit_d;
  logic [39:0]        m_data_q, m_data_d;

  logic s_fire;
  logic out_free;
  logic exec_en;

  // Cell row signals.
  logic [VALUE_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]   cell_hit;
  cell_ctrl_t         cell_ctrl  [DEPTH];

  // Operation decode.
  logic               is_ins;
  logic               is_rem;
  logic               use_match;
  logic [CW-1:0]      k_idx;
  status_e            status;
  logic [DEPTH-1:0]   ge;
  logic [DEPTH-1:0]   sel;
  logic [VALUE_W-1:0] removed;

  assign out_free = !m_valid_q || m_axis_tready;
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready = 1'b0;
    exec_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EXEC: exec_en       = out_free;
      default: ;
    endcase
  end

  // The cell row. Each cell talks only to its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] left_v;
    logic [VALUE_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    olir_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .new_value_i (value_q),
      .left_i      (left_v),
      .right_i     (right_v),
      .cmp_i       (s_axis_tdata[VALUE_W-1:0]),
      .value_o     (cell_value[i]),
      .hit_o       (cell_hit[i])
    );
  end

  // Hits are only meaningful for cells that hold a live entry.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit_d[i] = cell_hit[i] && (CW'(i) < count_q);
    end
  end

  // Decode the operation into an insert or remove at one cell index, or no change.
  always_comb begin
    is_ins    = 1'b0;
    is_rem    = 1'b0;
    use_match = 1'b0;
    k_idx     = '0;
    status    = STATUS_OK;
    unique case (mode_q)
      MODE_ADD_HEAD, MODE_APPEND, MODE_INSERT: begin
        if (count_q == CW'(DEPTH)) begin
          status = STATUS_FULL;
        end else begin
          is_ins = 1'b1;
          if (mode_q == MODE_ADD_HEAD) begin
            k_idx = '0;
          end else if (mode_q == MODE_APPEND ||
                       CMPW'(pos_q) >= CMPW'(count_q)) begin
            k_idx = count_q;
          end else begin
            k_idx = CW'(pos_q);
          end
        end
      end
      MODE_REM_HEAD: begin
        if (count_q == '0) begin
          status = STATUS_EMPTY;
        end else begin
          is_rem = 1'b1;
          k_idx  = '0;
        end
      end
      MODE_REM_MATCH: begin
        use_match = 1'b1;
        if (count_q == '0) begin
          status = STATUS_EMPTY;
        end else if (hit_q == '0) begin
          status = STATUS_NOTFOUND;
        end else begin
          is_rem = 1'b1;
        end
      end
      MODE_REM_TAIL: begin
        if (count_q == '0) begin
          status = STATUS_EMPTY;
        end else begin
          is_rem = 1'b1;
          k_idx  = count_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // ge marks every cell at or behind the target index; sel marks the target.
  // For a match removal the target is the first hit nearest the head.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (use_match) begin
        ge[i] = hit_q[i] || ((i > 0) && ge[(i > 0) ? i - 1 : 0]);
      end else begin
        ge[i] = (CW'(i) >= k_idx);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = ge[i] && !((i > 0) && ge[(i > 0) ? i - 1 : 0]);
    end
  end

  // Read out the removed entry and issue the shift commands.
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (is_rem && sel[i]) begin
        removed = removed | cell_value[i];
      end
      cell_ctrl[i].load       = exec_en && is_ins && sel[i];
      cell_ctrl[i].from_left  = exec_en && is_ins && ge[i] && !sel[i];
      cell_ctrl[i].from_right = exec_en && is_rem && ge[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (exec_en && is_ins) begin
      count_d = count_q + CW'(1);
    end else if (exec_en && is_rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (exec_en) begin
      m_valid_d = 1'b1;
      m_data_d  = {1'b0, LEN_W'(count_d), status, removed};
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Operand and result registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mode_q  <= mode_e'(s_axis_tuser);
      value_q <= s_axis_tdata[VALUE_W-1:0];
      pos_q   <= s_axis_tdata[VALUE_W +: POS_W];
      hit_q   <= hit_d;
    end
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: sv/olir_cell.sv
// One storage cell of the list: holds an entry, compares it, and shifts with its neighbors.
module olir_cell
  import olir_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic [VALUE_W-1:0] new_value_i,
  input  logic [VALUE_W-1:0] left_i,
  input  logic [VALUE_W-1:0] right_i,
  input  logic [VALUE_W-1:0] cmp_i,
  output logic [VALUE_W-1:0] value_o,
  output logic               hit_o
);

  logic [VALUE_W-1:0] value_q;
  logic [VALUE_W-1:0] value_d;

  always_comb begin
    priority if (ctrl_i.load) begin
      value_d = new_value_i;
    end else if (ctrl_i.from_left) begin
      value_d = left_i;
    end else if (ctrl_i.from_right) begin
      value_d = right_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign hit_o   = (value_q == cmp_i);

endmodule

// File: tb/tb.sv
// Self-checking testbench for the bounded ordered list with insert and remove.
`timescale 1ns / 100ps

module tb;
  import olir_pkg::*;

  localparam int unsigned LIST_DEPTH   = 16;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned TAIL_CYCLES  = 20;

  // Mode codes outside the defined set; the block must answer them without effect.
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] removed;
    status_e            status;
    logic [LEN_W-1:0]   length;
  } outcome_t;

  typedef struct {
    logic [MODE_W-1:0]  op;
    logic [VALUE_W-1:0] val;
    logic [POS_W-1:0]   pos;
    int                 reps;
    bit                 typed;
    outcome_t           want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // value [31:0], position [36:32], zero pad
  logic [2:0]  s_axis_tuser = '0;   // mode [2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // taken entry [31:0], status [33:32],
                                    // length [38:34], zero pad

  logic [VALUE_W-1:0] shadow_list[$];
  outcome_t           pending_outcomes[$];
  row_t               directed_rows[$];

  int unsigned beats_in, beats_out, mismatches, full_hits;
  int unsigned status_seen[4];
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned hold_reqs;
  outcome_t    mon_want, mon_got;

  ordered_list_insert_remove #(.DEPTH(LIST_DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Applies one operation to the shadow copy of the list and returns its outcome.
  function automatic outcome_t apply_operation(input logic [MODE_W-1:0] op,
                                               input logic [VALUE_W-1:0] val,
                                               input logic [POS_W-1:0] pos);
    outcome_t res;
    int       hit;
    res.removed = '0;
    res.status  = STATUS_OK;
    hit = -1;
    case (op)
      MODE_ADD_HEAD, MODE_APPEND, MODE_INSERT: begin
        if (shadow_list.size() >= LIST_DEPTH) begin
          res.status = STATUS_FULL;
        end else if (op == MODE_ADD_HEAD) begin
          shadow_list.push_front(val);
        end else if (op == MODE_APPEND || pos >= shadow_list.size()) begin
          shadow_list.push_back(val);
        end else begin
          shadow_list.insert(pos, val);
        end
      end
      MODE_REM_HEAD: begin
        if (shadow_list.size() == 0) res.status = STATUS_EMPTY;
        else res.removed = shadow_list.pop_front();
      end
      MODE_REM_TAIL: begin
        if (shadow_list.size() == 0) res.status = STATUS_EMPTY;
        else res.removed = shadow_list.pop_back();
      end
      MODE_REM_MATCH: begin
        if (shadow_list.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          // Scan from the tail so that the first match from the head wins.
          for (int i = shadow_list.size() - 1; i >= 0; i--)
            if (shadow_list[i] == val) hit = i;
          if (hit < 0) begin
            res.status = STATUS_NOTFOUND;
          end else begin
            res.removed = shadow_list[hit];
            shadow_list.delete(hit);
          end
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(shadow_list.size());
    return res;
  endfunction

  // Half of the values come from a small pool so that duplicates and matches occur.
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] pool[8];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'hDEAD_BEEF};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic add_row(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                         input logic [POS_W-1:0] pos, input int reps, input bit typed,
                         input logic [VALUE_W-1:0] removed, input status_e status,
                         input logic [LEN_W-1:0] length);
    row_t row;
    row.op    = op;
    row.val   = val;
    row.pos   = pos;
    row.reps  = reps;
    row.typed = typed;
    row.want  = '{removed, status, length};
    directed_rows.push_back(row);
  endtask

  // Offers one beat, honoring the burst and gap pattern, and records the
  // expected outcome once the beat is taken.
  task automatic send_beat(input logic [MODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                           input logic [POS_W-1:0] pos, input bit typed,
                           input outcome_t want);
    outcome_t predicted;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // Now and then a long burst without any gap.
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, pos, val};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predicted = apply_operation(op, val, pos);
    pending_outcomes.push_back(typed ? want : predicted);
    beats_in++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: ready pattern changes style every so often; each new hold-off
  // request keeps it low for a long stretch so the block backs up into its input.
  int unsigned rx_style, rx_left, hold_left, rx_tick, holds_taken;
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_reqs != holds_taken) begin
      holds_taken = hold_reqs;
      hold_left   = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 3);
      rx_left  = $urandom_range(30, 200);
    end else begin
      rx_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(0, 1);
        2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_out++;
      mon_got.removed = m_axis_tdata[31:0];
      mon_got.status  = status_e'(m_axis_tdata[33:32]);
      mon_got.length  = m_axis_tdata[38:34];
      status_seen[mon_got.status]++;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d: removed %h status %0d length %0d",
                   beats_out, mon_got.removed, mon_got.status, mon_got.length);
      end else begin
        mon_want = pending_outcomes.pop_front();
        if (mon_want.status == STATUS_FULL) full_hits++;
        if (mon_got !== mon_want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: removed exp %h got %h, status exp %0d got %0d, %s",
                     beats_out, mon_want.removed, mon_got.removed, mon_want.status,
                     mon_got.status, $sformatf("length exp %0d got %0d",
                     mon_want.length, mon_got.length));
        end
      end
    end
  end

  // Watchdog on cycles where neither side moves a beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned        random_count, r;
    bit                 fill_phase;
    logic [MODE_W-1:0]  op;
    logic [VALUE_W-1:0] val;
    outcome_t           no_want;

    no_want = '{32'h0, STATUS_OK, 5'd0};
    fill_phase = 1'b1;

    // Directed rows: empty-list removes, extremes, append on position at the
    // end and past it, not-found, unused codes, a full list, then draining.
    add_row(MODE_REM_HEAD,  32'h0,         5'd0,  1,  1, 32'h0, STATUS_EMPTY, 5'd0);
    add_row(MODE_REM_TAIL,  32'h0,         5'd0,  1,  1, 32'h0, STATUS_EMPTY, 5'd0);
    add_row(MODE_REM_MATCH, 32'h5,         5'd0,  1,  1, 32'h0, STATUS_EMPTY, 5'd0);
    add_row(MODE_ADD_HEAD,  32'h8000_0000, 5'd0,  1,  1, 32'h0, STATUS_OK,    5'd1);
    // Removing the only entry, which is also the head, by value.
    add_row(MODE_REM_MATCH, 32'h8000_0000, 5'd0,  1,  1, 32'h8000_0000, STATUS_OK, 5'd0);
    add_row(MODE_APPEND,    32'h7FFF_FFFF, 5'd0,  1,  1, 32'h0, STATUS_OK,    5'd1);
    add_row(MODE_INSERT,    32'hFFFF_FFFF, 5'd1,  1,  1, 32'h0, STATUS_OK,    5'd2);
    add_row(MODE_INSERT,    32'h0,         5'd16, 1,  1, 32'h0, STATUS_OK,    5'd3);
    add_row(MODE_INSERT,    32'h1234_5678, 5'd0,  1,  1, 32'h0, STATUS_OK,    5'd4);
    add_row(MODE_REM_MATCH, 32'h0000_5555, 5'd12, 1,  1, 32'h0, STATUS_NOTFOUND, 5'd4);
    add_row(MODE_SPARE_6,   32'hFFFF_FFFF, 5'd16, 1,  1, 32'h0, STATUS_OK,    5'd4);
    add_row(MODE_SPARE_7,   32'h0,         5'd0,  1,  1, 32'h0, STATUS_OK,    5'd4);
    add_row(MODE_REM_HEAD,  32'h0,         5'd0,  1,  1, 32'h1234_5678, STATUS_OK, 5'd3);
    add_row(MODE_REM_TAIL,  32'h0,         5'd0,  1,  1, 32'h0, STATUS_OK,    5'd2);
    add_row(MODE_INSERT,    32'hA5A5_A5A5, 5'd1,  1,  0, 32'h0, STATUS_OK,    5'd0);
    add_row(MODE_APPEND,    32'h0000_0001, 5'd0,  13, 0, 32'h0, STATUS_OK,    5'd0);
    add_row(MODE_ADD_HEAD,  32'h0000_0002, 5'd0,  1,  1, 32'h0, STATUS_FULL,  5'd16);
    add_row(MODE_APPEND,    32'h0000_0002, 5'd0,  1,  1, 32'h0, STATUS_FULL,  5'd16);
    add_row(MODE_INSERT,    32'h0000_0002, 5'd12, 1,  1, 32'h0, STATUS_FULL,  5'd16);
    add_row(MODE_REM_MATCH, 32'h0000_0001, 5'd0,  1,  1, 32'h1,  STATUS_OK,   5'd15);
    add_row(MODE_REM_MATCH, 32'hFFFF_FFFF, 5'd0,  1,  1, 32'hFFFF_FFFF, STATUS_OK, 5'd14);
    add_row(MODE_REM_TAIL,  32'h0,         5'd0,  14, 0, 32'h0, STATUS_OK,    5'd0);
    add_row(MODE_REM_TAIL,  32'h0,         5'd0,  1,  1, 32'h0, STATUS_EMPTY, 5'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      for (int k = 0; k < directed_rows[i].reps; k++)
        send_beat(directed_rows[i].op, directed_rows[i].val, directed_rows[i].pos,
                  directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // Random part: alternate between fill-leaning and drain-leaning stretches so
    // the list keeps running between empty and full.
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      if (shadow_list.size() == LIST_DEPTH && fill_phase && $urandom_range(0, 2) == 0)
        fill_phase = 1'b0;
      else if (shadow_list.size() == 0 && !fill_phase && $urandom_range(0, 2) == 0)
        fill_phase = 1'b1;
      else if ($urandom_range(0, 49) == 0)
        fill_phase = !fill_phase;

      r = $urandom_range(0, 99);
      if (r == 0) begin
        op = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      end else begin
        if (!fill_phase) r = 99 - r;
        if (r < 25)      op = MODE_ADD_HEAD;
        else if (r < 50) op = MODE_APPEND;
        else if (r < 75) op = MODE_INSERT;
        else if (r < 83) op = MODE_REM_HEAD;
        else if (r < 92) op = MODE_REM_MATCH;
        else             op = MODE_REM_TAIL;
        random_count++;
      end

      if (op == MODE_REM_MATCH && shadow_list.size() != 0 && $urandom_range(0, 3) != 0)
        val = shadow_list[$urandom_range(0, shadow_list.size() - 1)];
      else
        val = pick_value();

      send_beat(op, val, POS_W'($urandom_range(0, LIST_DEPTH)), 1'b0, no_want);

      if (random_count == 300 || random_count == 900) hold_reqs++;
      if (random_count % 350 == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_outcomes.size() != 0) mismatches += pending_outcomes.size();

    $display("Run moved %0d beats in and %0d results out, %0d of them on a full list.",
             beats_in, beats_out, full_hits);
    $display("Status counts: ok %0d, empty %0d, not found %0d, full %0d; failures %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
sv/olir_pkg.sv
sv/olir_cell.sv
sv/ordered_list_insert_remove.sv
tb/tb.sv
